// ===== design/plcm_pkg.sv =====
// ============================================================================
// plcm_pkg - colour map shared definitions
// Widths, request codes, register indexes and the structs passed between
// the sequencer, the serial divider and the top level.
// ============================================================================
package plcm_pkg;

    localparam int NUM_ENTRIES_DEF = 8;

    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;     // Q16 position, 65536 is one
    localparam int CH_W     = 8;
    localparam int COL_W    = 3 * CH_W;
    localparam int FRAC_W   = 16;

    // signed sample position t and the difference t - p0
    localparam int T_W    = SAMPLE_W + FRAC_W + 2;
    localparam int DIFF_W = T_W + 1;

    // serial divider: {num, 16 zero bits} / den, both magnitudes
    localparam int DIV_DEN_W = POS_W;
    localparam int DIV_NUM_W = DIV_DEN_W + FRAC_W;
    localparam int DIV_REM_W = DIV_DEN_W + 1;

    // configuration port
    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 16'h0000;
    localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 16'hFFFF;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP    = 2'd2;

    localparam logic [POS_W-1:0] ONE_Q16      = 17'h10000;
    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic                 start;
        logic [DIV_DEN_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } res_t;

endpackage

// ===== design/plcm_req_if.sv =====
// ============================================================================
// plcm_req_if - request channel
// valid/ready channel carrying one table or map request.
// ============================================================================
interface plcm_req_if
    import plcm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    point_position;
    logic [CH_W-1:0]     point_red;
    logic [CH_W-1:0]     point_green;
    logic [CH_W-1:0]     point_blue;

    modport source (
        output valid, req_type, sample, point_position,
               point_red, point_green, point_blue,
        input  ready
    );

    modport sink (
        input  valid, req_type, sample, point_position,
               point_red, point_green, point_blue,
        output ready
    );
endinterface

// ===== design/plcm_rsp_if.sv =====
// ============================================================================
// plcm_rsp_if - result channel
// valid/ready channel carrying one RGBA colour.
// ============================================================================
interface plcm_rsp_if
    import plcm_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (
        output valid, red, green, blue, alpha,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, alpha,
        output ready
    );
endinterface

// ===== design/plcm_div.sv =====
// ============================================================================
// plcm_div - serial restoring divider
// Divides {num, 16 zero bits} by den, one quotient bit per cycle.
// ============================================================================
module plcm_div
    import plcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_REM_W-1:0] shifted;
    logic [DIV_REM_W-1:0] diff;
    logic                 fits;

    assign shifted = {rem_reg[DIV_REM_W-2:0], quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            quo_reg <= {cmd.num, {FRAC_W{1'b0}}};
            den_reg <= cmd.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff : shifted;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== design/plcm_ctrl.sv =====
// ============================================================================
// plcm_ctrl - point table and map sequencer
// Holds the control points and steps one map request through normalize,
// point search, weight and per-channel blend using the shared divider.
// ============================================================================
module plcm_ctrl
    import plcm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] range_low,
    input  logic [SAMPLE_W-1:0] range_high,
    plcm_req_if.sink            req,
    output div_cmd_t            div_cmd,
    input  div_rsp_t            div_rsp,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res
);

    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int ENT_W = POS_W + COL_W;
    localparam int MIX_W = CH_W + POS_W;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_TDIV     = 12'b0000_0000_0010,
        S_TWAIT    = 12'b0000_0000_0100,
        S_SCAN_RD  = 12'b0000_0000_1000,
        S_SCAN_CMP = 12'b0000_0001_0000,
        S_SEG_RD0  = 12'b0000_0010_0000,
        S_SEG_RD1  = 12'b0000_0100_0000,
        S_SEG_LAT  = 12'b0000_1000_0000,
        S_WDEC     = 12'b0001_0000_0000,
        S_WWAIT    = 12'b0010_0000_0000,
        S_MIX      = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    // a*(1-w) + b*w in Q16, truncated
    function automatic logic [CH_W-1:0] blend(
        input logic [CH_W-1:0]  a,
        input logic [CH_W-1:0]  b,
        input logic [POS_W-1:0] w
    );
        logic [MIX_W-1:0] sum;
        sum = {{POS_W{1'b0}}, a} * {{CH_W{1'b0}}, ONE_Q16 - w}
            + {{POS_W{1'b0}}, b} * {{CH_W{1'b0}}, w};
        return sum[FRAC_W+CH_W-1:FRAC_W];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]     count_reg;
    logic [ENT_W-1:0]     mem [NUM_ENTRIES];
    logic [ENT_W-1:0]     mem_q_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic [SAMPLE_W-1:0]  sample_reg;
    logic signed [T_W-1:0] t_reg;
    logic                 neg_reg;
    logic                 single_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     lo_reg;
    logic [POS_W-1:0]     p0_reg;
    logic [COL_W-1:0]     c0_reg;
    logic [COL_W-1:0]     c1_reg;
    logic [DIFF_W-1:0]    diff_reg;
    logic [POS_W:0]       den_reg;
    logic [POS_W-1:0]     w_reg;
    logic [1:0]           ch_reg;
    res_t                 res_reg;

    logic                 accept;
    logic                 full;
    logic                 wr_en;
    logic [POS_W-1:0]     ent_pos;
    logic [COL_W-1:0]     ent_col;
    logic [POS_W-1:0]     t_num;
    logic [POS_W-1:0]     t_den;
    logic [POS_W-1:0]     t_num_mag;
    logic [POS_W-1:0]     t_den_mag;
    logic [T_W-1:0]       q_ext;
    logic                 scan_last;
    logic [CNT_W-1:0]     lo_max;
    logic [IDX_W-1:0]     lo_clamp;
    logic [DIFF_W-1:0]    diff_neg;
    logic [DIFF_W-1:0]    diff_mag;
    logic [POS_W:0]       den_neg;
    logic [POS_W-1:0]     den_mag;
    logic                 w_zero;
    logic                 w_full;
    logic [CH_W-1:0]      ch_a;
    logic [CH_W-1:0]      ch_b;
    logic [CH_W-1:0]      ch_mix;

    assign accept  = req.valid && req.ready;
    assign full    = count_reg == CNT_W'(NUM_ENTRIES);
    assign wr_en   = accept && (req.req_type == REQ_APPEND) && !full;
    assign ent_pos = mem_q_reg[ENT_W-1:COL_W];
    assign ent_col = mem_q_reg[COL_W-1:0];

    // sample normalize operands, 17-bit two's complement
    assign t_num     = {1'b0, sample_reg} - {1'b0, range_low};
    assign t_den     = {1'b0, range_high} - {1'b0, range_low};
    assign t_num_mag = t_num[POS_W-1] ? -t_num : t_num;
    assign t_den_mag = t_den[POS_W-1] ? -t_den : t_den;
    assign q_ext     = {1'b0, div_rsp.quot};

    assign scan_last = CNT_W'(idx_reg) == (count_reg - 1'b1);
    assign lo_max    = count_reg - CNT_W'(2);
    assign lo_clamp  = (CNT_W'(lo_reg) > lo_max) ? lo_max[IDX_W-1:0] : lo_reg;

    // weight decision: negative or zero gives 0, |diff| >= |den| saturates
    assign diff_neg = -diff_reg;
    assign diff_mag = diff_reg[DIFF_W-1] ? diff_neg : diff_reg;
    assign den_neg  = -den_reg;
    assign den_mag  = den_reg[POS_W] ? den_neg[POS_W-1:0] : den_reg[POS_W-1:0];
    assign w_zero   = (den_reg == '0) || (diff_reg == '0)
                    || (diff_reg[DIFF_W-1] ^ den_reg[POS_W]);
    assign w_full   = diff_mag >= {{(DIFF_W-POS_W){1'b0}}, den_mag};

    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                ch_a = c0_reg[3*CH_W-1:2*CH_W];
                ch_b = c1_reg[3*CH_W-1:2*CH_W];
            end
            CH_GREEN:
            begin
                ch_a = c0_reg[2*CH_W-1:CH_W];
                ch_b = c1_reg[2*CH_W-1:CH_W];
            end
            default:
            begin
                ch_a = c0_reg[CH_W-1:0];
                ch_b = c1_reg[CH_W-1:0];
            end
        endcase
    end

    assign ch_mix = blend(ch_a, ch_b, w_reg);

    always_comb
    begin
        case (state_reg)
            S_SCAN_RD: rd_addr = idx_reg;
            S_SEG_RD0: rd_addr = single_reg ? '0 : lo_clamp;
            S_SEG_RD1: rd_addr = IDX_W'(lo_reg + 1'b1);
            default:   rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.num   = t_num_mag;
        div_cmd.den   = t_den_mag;
        if (state_reg == S_TDIV)
        begin
            div_cmd.start = t_den != '0;
        end
        else if (state_reg == S_WDEC)
        begin
            div_cmd.start = !w_zero && !w_full;
            div_cmd.num   = diff_mag[POS_W-1:0];
            div_cmd.den   = den_mag;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.req_type == REQ_MAP)
                begin
                    if (count_reg == '0)
                        state_next = S_DONE;
                    else if (count_reg == CNT_W'(1))
                        state_next = S_SEG_RD0;
                    else
                        state_next = S_TDIV;
                end
            end
            S_TDIV:     state_next = (t_den == '0) ? S_SCAN_RD : S_TWAIT;
            S_TWAIT:    state_next = div_rsp.done ? S_SCAN_RD : S_TWAIT;
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: state_next = scan_last ? S_SEG_RD0 : S_SCAN_RD;
            S_SEG_RD0:  state_next = S_SEG_RD1;
            S_SEG_RD1:  state_next = single_reg ? S_MIX : S_SEG_LAT;
            S_SEG_LAT:  state_next = S_WDEC;
            S_WDEC:     state_next = (w_zero || w_full) ? S_MIX : S_WWAIT;
            S_WWAIT:    state_next = div_rsp.done ? S_MIX : S_WWAIT;
            S_MIX:      state_next = (ch_reg == CH_BLUE) ? S_DONE : S_MIX;
            S_DONE:     state_next = res_ready ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && req.req_type == REQ_CLEAR)
                count_reg <= '0;
            else if (wr_en)
                count_reg <= count_reg + 1'b1;
        end
    end

    // point table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {req.point_position, req.point_red,
                                          req.point_green, req.point_blue};
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sample_reg <= req.sample;
                single_reg <= count_reg == CNT_W'(1);
                lo_reg     <= '0;
                res_reg    <= '0;
            end
            S_TDIV:
            begin
                neg_reg <= t_num[POS_W-1] ^ t_den[POS_W-1];
                t_reg   <= '0;
                idx_reg <= '0;
            end
            S_TWAIT:
            begin
                if (div_rsp.done)
                    t_reg <= neg_reg ? -q_ext : q_ext;
            end
            S_SCAN_CMP:
            begin
                if (t_reg >= $signed({{(T_W-POS_W){1'b0}}, ent_pos}))
                    lo_reg <= idx_reg;
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
            S_SEG_RD0:
            begin
                if (!single_reg)
                    lo_reg <= lo_clamp;
            end
            S_SEG_RD1:
            begin
                p0_reg <= ent_pos;
                c0_reg <= ent_col;
                c1_reg <= ent_col;
                w_reg  <= '0;
                ch_reg <= CH_RED;
            end
            S_SEG_LAT:
            begin
                c1_reg   <= ent_col;
                diff_reg <= {t_reg[T_W-1], t_reg} - {{(DIFF_W-POS_W){1'b0}}, p0_reg};
                den_reg  <= {1'b0, ent_pos} - {1'b0, p0_reg};
            end
            S_WDEC:
            begin
                w_reg <= (!w_zero && w_full) ? ONE_Q16 : '0;
            end
            S_WWAIT:
            begin
                if (div_rsp.done)
                    w_reg <= div_rsp.quot[POS_W-1:0];
            end
            S_MIX:
            begin
                case (ch_reg)
                    CH_RED:   res_reg.red   <= ch_mix;
                    CH_GREEN: res_reg.green <= ch_mix;
                    default:  res_reg.blue  <= ch_mix;
                endcase
                res_reg.alpha <= ALPHA_OPAQUE;
                ch_reg        <= ch_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

endmodule

// ===== design/piecewise_linear_colour_map_top.sv =====
// ============================================================================
// piecewise_linear_colour_map_top - piecewise-linear colour map
// Control-point table with a serial-divide map engine, APB range registers
// and a registered result channel.
// ============================================================================
//
//  channel  dir  handshake              carries
//  -------  ---  ---------------------  -------------------------------------
//  req      in   valid & ready          req_type, sample, point position/RGB
//  rsp      out  valid & ready          red, green, blue, alpha
//  apb      in   psel & penable & pwr   range_low (0x0), range_high (0x4)
//
//  Clear and append requests leave the engine idle, so ready stays high.
//  A map request uses the 33-step serial divider up to twice (sample
//  normalize, then segment weight) and reads each stored point in its
//  search through the single-port table. Empty or single-point tables
//  skip the divides.
//  The result sits in an output register; a stall on rsp holds it and the
//  engine waits only when a second result is ready before the first is taken.
//  Reset is asynchronous; it empties the table and restores the range to
//  the full 16-bit span. The table itself has no clearing pass.
//
module piecewise_linear_colour_map_top
    import plcm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,

    plcm_req_if.sink              req,
    plcm_rsp_if.source            rsp
);

    logic [SAMPLE_W-1:0]  range_low_reg;
    logic [SAMPLE_W-1:0]  range_high_reg;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    logic res_valid;
    logic res_ready;
    res_t res;

    logic out_valid_reg;
    res_t out_data_reg;

    // ------------------------------------------------------------------
    // Range registers. Zero-wait APB; write lands on the access cycle.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RANGE_LOW:  range_low_reg  <= pwdata[SAMPLE_W-1:0];
                REG_RANGE_HIGH: range_high_reg <= pwdata[SAMPLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RANGE_HIGH: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, range_high_reg};
            default:        prdata = {{(DATA_W-SAMPLE_W){1'b0}}, range_low_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Map engine and its shared divider
    // ------------------------------------------------------------------
    plcm_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .req        (req),
        .div_cmd    (div_cmd),
        .div_rsp    (div_rsp),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    plcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Output register: engine hands over whenever the slot is free or
    // being drained this cycle.
    // ------------------------------------------------------------------
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.red   = out_data_reg.red;
    assign rsp.green = out_data_reg.green;
    assign rsp.blue  = out_data_reg.blue;
    assign rsp.alpha = out_data_reg.alpha;

endmodule

// ===== design/plcm_chk.sv =====
// ============================================================================
// plcm_chk - colour map port checker
// Watches the request and result channels of the top level.
// ============================================================================
module plcm_chk
    import plcm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic [REQ_W-1:0] req_type,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [CH_W-1:0]  red,
    input logic [CH_W-1:0]  green,
    input logic [CH_W-1:0]  blue,
    input logic [CH_W-1:0]  alpha
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({red, green, blue, alpha}))
        else $error("result changed while stalled");

    a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (alpha == 8'h00) || (alpha == ALPHA_OPAQUE))
        else $error("alpha neither transparent nor opaque");

    // a transparent result (empty table) is black
    a_empty_black: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (alpha == 8'h00) |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("transparent result carries colour");

    // map engine is busy the cycle after a map request
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_MAP) |=> !req_ready)
        else $error("ready high right after a map request");

endmodule

bind piecewise_linear_colour_map_top plcm_chk u_plcm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .red       (rsp.red),
    .green     (rsp.green),
    .blue      (rsp.blue),
    .alpha     (rsp.alpha)
);

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench - piecewise-linear colour map
// Drives table and map requests into the colour map through bursty traffic,
// predicts map results from its own copy of the point table and range (or uses a
// literal) and compares each colour, channel by channel, as it leaves the block.
// ============================================================================
module testbench;
    import plcm_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------------
    localparam int N_POINTS    = NUM_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;  // several times the slowest run
    localparam int DRAIN_WAIT  = 200;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 100;        // ~700 random requests in all

    // Request code 3 has no meaning; the block drops it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One request as the testbench sees it. colour is {red, green, blue}.
    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    position;
        logic [COL_W-1:0]    colour;
    } map_req_t;

    // Directed table row: a literal colour is used where it is obvious.
    typedef struct packed {
        map_req_t req;
        logic     has_want;
        res_t     want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    plcm_req_if req_ch ();
    plcm_rsp_if rsp_ch ();

    // Result-side ready has one driver, the stall pattern below.
    logic sink_ready = 1'b0;
    assign rsp_ch.ready = sink_ready;

    piecewise_linear_colour_map_top #(
        .NUM_ENTRIES (N_POINTS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block: point table, point count and the range registers
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]    map_pos [N_POINTS];
    logic [COL_W-1:0]    map_col [N_POINTS];
    int                  map_count = 0;
    logic [SAMPLE_W-1:0] range_lo  = RANGE_LOW_RST;
    logic [SAMPLE_W-1:0] range_hi  = RANGE_HIGH_RST;

    res_t pending_colours [$];   // colours still owed by the block, oldest first
    int   errors      = 0;
    int   items_done  = 0;       // requests that were not dropped
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   stall_mode  = 0;

    // Linear blend of one 8-bit channel with a Q16 weight, truncated.
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input longint w);
        longint mix;
        mix = longint'(a) * (longint'(ONE_Q16) - w) + longint'(b) * w;
        return CH_W'(mix >> FRAC_W);
    endfunction

    // Colour that a map request with this sample should return right now.
    function automatic res_t predict_colour(input logic [SAMPLE_W-1:0] s);
        res_t             r;
        longint           t;
        longint           den;
        longint           p0;
        longint           p1;
        longint           w;
        int               lo;
        int               i;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        r  = '0;
        t  = 0;
        w  = 0;
        lo = 0;
        // empty table: black, fully transparent
        if (map_count == 0)
            return r;
        // one point: its own colour, no divide
        if (map_count == 1)
        begin
            r.red   = map_col[0][23:16];
            r.green = map_col[0][15:8];
            r.blue  = map_col[0][7:0];
            r.alpha = ALPHA_OPAQUE;
            return r;
        end
        // normalize; a zero range leaves t at zero, a reversed one flips sign
        den = longint'(range_hi) - longint'(range_lo);
        if (den != 0)
            t = ((longint'(s) - longint'(range_lo)) * longint'(ONE_Q16)) / den;
        // last point at or below t, held inside the last segment
        for (i = 0; i < map_count; i++)
            if (t >= longint'(map_pos[i]))
                lo = i;
        if (lo > map_count - 2)
            lo = map_count - 2;
        // segment weight; zero width gives zero, negative width divides as is
        p0 = longint'(map_pos[lo]);
        p1 = longint'(map_pos[lo + 1]);
        if (p1 != p0)
            w = ((t - p0) * longint'(ONE_Q16)) / (p1 - p0);
        if (w < 0)
            w = 0;
        if (w > longint'(ONE_Q16))
            w = longint'(ONE_Q16);
        c0 = map_col[lo];
        c1 = map_col[lo + 1];
        r.red   = blend(c0[23:16], c1[23:16], w);
        r.green = blend(c0[15:8],  c1[15:8],  w);
        r.blue  = blend(c0[7:0],   c1[7:0],   w);
        r.alpha = ALPHA_OPAQUE;
        return r;
    endfunction

    // Update the shadow for an accepted request; 0 means the block drops it.
    function automatic bit apply_request(input map_req_t r);
        case (r.kind)
            REQ_CLEAR:
            begin
                map_count = 0;
                return 1'b1;
            end
            REQ_APPEND:
            begin
                if (map_count >= N_POINTS)
                    return 1'b0;          // table full, append dropped
                map_pos[map_count] = r.position;
                map_col[map_count] = r.colour;
                map_count++;
                return 1'b1;
            end
            REQ_MAP:
            begin
                pending_colours.insert(pending_colours.size(), predict_colour(r.sample));
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic map_req_t make_req(input logic [REQ_W-1:0]    kind,
                                          input logic [SAMPLE_W-1:0] sample,
                                          input logic [POS_W-1:0]    position,
                                          input logic [COL_W-1:0]    colour);
        map_req_t r;
        r.kind     = kind;
        r.sample   = sample;
        r.position = position;
        r.colour   = colour;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [REQ_W-1:0]    kind,
                                      input logic [SAMPLE_W-1:0] sample,
                                      input logic [POS_W-1:0]    position,
                                      input logic [COL_W-1:0]    colour,
                                      input logic                has_want,
                                      input res_t                want);
        stim_row_t d;
        d.req      = make_req(kind, sample, position, colour);
        d.has_want = has_want;
        d.want     = want;
        return d;
    endfunction

    // Samples lean toward the range ends and the 16-bit extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return range_lo;
            3:       return range_hi;
            4:       return range_lo + SAMPLE_W'($urandom_range(0, 3));
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_colour();
        return COL_W'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Present one request and hold it until accepted. valid stays high on
    // return; pace() decides whether a gap follows.
    task automatic send_req(input map_req_t r, input bit use_want, input res_t want);
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= r.kind;
        req_ch.sample         <= r.sample;
        req_ch.point_position <= r.position;
        req_ch.point_red      <= r.colour[23:16];
        req_ch.point_green    <= r.colour[15:8];
        req_ch.point_blue     <= r.colour[7:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (use_want)
        begin
            pending_colours.insert(pending_colours.size(), want);
            items_done++;
        end
        else if (apply_request(r))
            items_done++;
    endtask

    // Bursty sender: mostly short bursts, now and then a long unbroken run.
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    task automatic push(input map_req_t r);
        send_req(r, 1'b0, '0);
        pace();
    endtask

    // Stop sending, let every owed colour arrive, then let the engine go quiet.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_colours.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port (APB style, setup and access phases)
    // ------------------------------------------------------------------------
    function automatic logic [CFG_ADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
        return CFG_ADDR_W'(idx) << 2;
    endfunction

    // One transfer, ending with psel and penable low, which keeps back-to-back calls clean.
    task automatic cfg_xfer(input logic [REG_IDX_W-1:0] idx, input bit wr,
                            input logic [SAMPLE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= reg_addr(idx);
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!wr && prdata[SAMPLE_W-1:0] !== value)
        begin
            $display("%0t: register %0d read back, expected %04h, got %04h",
                     $time, idx, value, prdata[SAMPLE_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write both range registers, mirror them, and read them back.
    task automatic set_range(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
        cfg_xfer(REG_RANGE_LOW,  1'b1, lo);
        cfg_xfer(REG_RANGE_HIGH, 1'b1, hi);
        range_lo = lo;
        range_hi = hi;
        cfg_xfer(REG_RANGE_LOW,  1'b0, lo);
        cfg_xfer(REG_RANGE_HIGH, 1'b0, hi);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------
    // Clear, build a table (mostly sorted, sometimes overfull), then map.
    task automatic build_and_map();
        int n_points;
        int n_maps;
        int i;
        int p;
        bit sorted;
        push(make_req(REQ_CLEAR, SAMPLE_W'($urandom()), POS_W'($urandom()), pick_colour()));
        n_points = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 10) : $urandom_range(2, 8);
        sorted   = ($urandom_range(0, 4) != 0);
        p        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20000);
        for (i = 0; i < n_points; i++)
        begin
            push(make_req(REQ_APPEND, SAMPLE_W'($urandom()), POS_W'(p), pick_colour()));
            if (!sorted)
                p = $urandom_range(0, 65536);
            else if ($urandom_range(0, 7) != 0)   // step 0 makes a zero-width segment
            begin
                p = p + $urandom_range(0, 24000);
                if (p > 65536)
                    p = 65536;
            end
        end
        n_maps = $urandom_range(1, 8);
        for (i = 0; i < n_maps; i++)
            push(make_req(REQ_MAP, pick_sample(), POS_W'($urandom_range(0, 65536)),
                          pick_colour()));
    endtask

    // Loose requests of any code, unused code 3 included.
    task automatic noise();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
            push(make_req(REQ_W'($urandom_range(0, 3)), SAMPLE_W'($urandom()),
                          POS_W'($urandom_range(0, 65536)), pick_colour()));
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = items_done + count;
        while (items_done < goal)
            if ($urandom_range(0, 4) != 0)
                build_and_map();
            else
                noise();
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------
    // Mode is redrawn at random from: open, coin flip, 1-in-16, long stall.
    always @(posedge clk)
    begin
        if (cycle_count % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       sink_ready <= 1'b1;
            1:       sink_ready <= 1'($urandom_range(0, 1));
            2:       sink_ready <= (cycle_count % 16 == 0);
            default: sink_ready <= (cycle_count % 128 >= 100);
        endcase
    end

    task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_colours.size() == 0)
            begin
                $display("%0t: colour with no map request owed, expected none, got %02h%02h%02h%02h",
                         $time, rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha);
                errors++;
            end
            else
            begin
                want = pending_colours.pop_front();
                check_channel("red",   want.red,   rsp_ch.red);
                check_channel("green", want.green, rsp_ch.green);
                check_channel("blue",  want.blue,  rsp_ch.blue);
                check_channel("alpha", want.alpha, rsp_ch.alpha);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    stim_row_t directed [$];

    // Append one row to the directed table.
    task automatic add_row(input stim_row_t d);
        directed.insert(directed.size(), d);
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] lo_set;
        logic [SAMPLE_W-1:0] hi_set;
        int                  ph;
        int                  k;

        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_CLEAR;
        req_ch.sample         <= '0;
        req_ch.point_position <= '0;
        req_ch.point_red      <= '0;
        req_ch.point_green    <= '0;
        req_ch.point_blue     <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;

        // Directed requests, run at the reset range (0 .. 65535).
        // empty table: black, alpha 0
        add_row(row(REQ_MAP,    16'h0000, 17'h00000, 24'h000000, 1, 32'h00000000));
        // single point: its colour wherever the sample falls
        add_row(row(REQ_APPEND, 16'h0000, 17'h08000, 24'h123456, 0, '0));
        add_row(row(REQ_MAP,    16'h0000, 17'h00000, 24'h000000, 1, 32'h123456FF));
        add_row(row(REQ_MAP,    16'hFFFF, 17'h1FFFF, 24'hFFFFFF, 1, 32'h123456FF));
        // black to white over the whole span; both ends read off directly
        add_row(row(REQ_CLEAR,  16'hFFFF, 17'h1FFFF, 24'hFFFFFF, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h00000, 24'h000000, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h10000, 24'hFFFFFF, 0, '0));
        add_row(row(REQ_MAP,    16'h0000, 17'h00000, 24'h000000, 1, 32'h000000FF));
        add_row(row(REQ_MAP,    16'hFFFF, 17'h00000, 24'h000000, 1, 32'hFFFFFFFF));
        add_row(row(REQ_MAP,    16'h8000, 17'h00000, 24'h000000, 0, '0));
        // unused code: dropped, table untouched
        add_row(row(REQ_UNUSED, 16'hFFFF, 17'h1FFFF, 24'hFFFFFF, 0, '0));
        // unsorted points with a zero-width segment; sample below the first point
        add_row(row(REQ_CLEAR,  16'h0000, 17'h00000, 24'h000000, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h0C000, 24'hF08010, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h04000, 24'h1080F0, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h04000, 24'hAA55AA, 0, '0));
        add_row(row(REQ_MAP,    16'h0000, 17'h00000, 24'h000000, 0, '0));
        add_row(row(REQ_MAP,    16'h8000, 17'h00000, 24'h000000, 0, '0));
        add_row(row(REQ_MAP,    16'hFFFF, 17'h00000, 24'h000000, 0, '0));
        // fill the table, then one append too many
        add_row(row(REQ_APPEND, 16'h0000, 17'h06000, 24'h00FF00, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h09000, 24'hFF0000, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h0E000, 24'h0000FF, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h0F000, 24'h7F7F7F, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h10000, 24'hFFFFFF, 0, '0));
        add_row(row(REQ_APPEND, 16'h0000, 17'h00000, 24'h000000, 0, '0));
        add_row(row(REQ_MAP,    16'hE800, 17'h00000, 24'h000000, 0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the range registers
        cfg_xfer(REG_RANGE_LOW,  1'b0, RANGE_LOW_RST);
        cfg_xfer(REG_RANGE_HIGH, 1'b0, RANGE_HIGH_RST);

        for (k = 0; k < directed.size(); k++)
        begin
            send_req(directed[k].req, directed[k].has_want, directed[k].want);
            pace();
        end

        // Random phases, each at its own range setting: full span, a window,
        // zero range, reversed, minimal, random, reversed by one.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:       begin lo_set = 16'h0000; hi_set = 16'hFFFF; end
                1:       begin lo_set = 16'h4000; hi_set = 16'hC000; end
                2:       begin lo_set = 16'h1234; hi_set = 16'h1234; end
                3:       begin lo_set = 16'hFFFF; hi_set = 16'h0000; end
                4:       begin lo_set = 16'h0000; hi_set = 16'h0001; end
                5:
                begin
                    lo_set = SAMPLE_W'($urandom());
                    hi_set = SAMPLE_W'($urandom());
                end
                default: begin lo_set = 16'h8000; hi_set = 16'h7FFF; end
            endcase
            settle();
            set_range(lo_set, hi_set);
            random_phase(PHASE_ITEMS);
        end

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
